FILE: hw/rtl/usbctl_pkg.sv
// ----------------------------------------------------------------------------
// usbctl_pkg
// Types and codes shared by the endpoint-zero control-transfer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package usbctl_pkg;

    // Configuration port geometry: five 32-bit registers at 4-byte spacing.
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    // Register indexes.
    localparam logic [2:0] REG_DEVICE_DESC  = 3'd0;
    localparam logic [2:0] REG_CONFIG_DESC  = 3'd1;
    localparam logic [2:0] REG_VENDOR_STR   = 3'd2;
    localparam logic [2:0] REG_PRODUCT_STR  = 3'd3;
    localparam logic [2:0] REG_SERIAL_STR   = 3'd4;

    // Token events.
    localparam logic [1:0] FUNC_SETUP = 2'd0;
    localparam logic [1:0] FUNC_OUT   = 2'd1;
    localparam logic [1:0] FUNC_IN    = 2'd2;

    // Transfer phases.
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_STATUS_IN  = 3'd1;
    localparam logic [2:0] PH_STATUS_OUT = 3'd2;
    localparam logic [2:0] PH_IN_DATA    = 3'd3;
    localparam logic [2:0] PH_LAST_IN    = 3'd4;
    localparam logic [2:0] PH_OUT_DATA   = 3'd5;

    // Transmit actions.
    localparam logic [1:0] TX_NONE  = 2'd0;
    localparam logic [1:0] TX_STALL = 2'd1;
    localparam logic [1:0] TX_DATA  = 2'd2;
    localparam logic [1:0] TX_ZLP   = 2'd3;

    // Data sources.
    localparam logic [3:0] SRC_NONE    = 4'd0;
    localparam logic [3:0] SRC_DEVICE  = 4'd1;
    localparam logic [3:0] SRC_CONFIG  = 4'd2;
    localparam logic [3:0] SRC_STRING0 = 4'd3;
    localparam logic [3:0] SRC_ZERO    = 4'd7;
    localparam logic [3:0] SRC_STATUS  = 4'd8;
    localparam logic [3:0] SRC_USER    = 4'd9;

    // Standard request codes, descriptor types and recipients.
    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_ASSIGN_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] DESC_DEVICE = 8'd1;
    localparam logic [7:0] DESC_CONFIG = 8'd2;
    localparam logic [7:0] DESC_STRING = 8'd3;
    localparam logic [4:0] RECIP_DEVICE    = 5'd0;
    localparam logic [4:0] RECIP_INTERFACE = 5'd1;
    localparam logic [4:0] RECIP_ENDPOINT  = 5'd2;
    localparam logic [1:0] REQ_KIND_STANDARD = 2'd0;

    // Fixed reply lengths and the vendor "data on the fly" marker.
    localparam logic [15:0] STRING0_LEN       = 16'd4;
    localparam logic [15:0] ZERO_BYTE_LEN     = 16'd1;
    localparam logic [15:0] STATUS_BYTES_LEN  = 16'd2;
    localparam logic [15:0] VENDOR_ON_THE_FLY = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  req_type;
        logic [7:0]  req_code;
        logic [15:0] req_value;
        logic [15:0] req_length;
        logic [6:0]  rx_count;
        logic [15:0] vendor_reply_len;
    } t_item;

    typedef struct packed {
        logic [1:0]  tx_action;
        logic [6:0]  tx_count;
        logic [3:0]  source_select;
        logic [15:0] source_offset;
        logic        out_deliver;
        logic [6:0]  out_bytes;
        logic        address_write;
        logic [7:0]  new_address;
        logic [2:0]  phase;
        logic        protocol_error;
    } t_result;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] byte_offset;
        logic [15:0] byte_total;
        logic [7:0]  saved_type;
        logic [7:0]  saved_code;
        logic [15:0] saved_value;
        logic [15:0] saved_length;
        logic [3:0]  saved_source;
    } t_state;

    typedef struct packed {
        logic [7:0] device_desc_len;
        logic [9:0] config_desc_len;
        logic [7:0] vendor_str_len;
        logic [7:0] product_str_len;
        logic [7:0] serial_str_len;
    } t_cfg;

endpackage

`default_nettype wire

FILE: hw/rtl/usbctl_if.sv
// ----------------------------------------------------------------------------
// usbctl_if
// Valid/ready channels for token events in and transmit results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface usbctl_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  req_type;
    logic [7:0]  req_code;
    logic [15:0] req_value;
    logic [15:0] req_length;
    logic [6:0]  rx_count;
    logic [15:0] vendor_reply_len;

    modport source (
        output valid, func, req_type, req_code, req_value, req_length, rx_count,
               vendor_reply_len,
        input  ready
    );
    modport sink (
        input  valid, func, req_type, req_code, req_value, req_length, rx_count,
               vendor_reply_len,
        output ready
    );
endinterface

interface usbctl_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  tx_action;
    logic [6:0]  tx_count;
    logic [3:0]  source_select;
    logic [15:0] source_offset;
    logic        out_deliver;
    logic [6:0]  out_bytes;
    logic        address_write;
    logic [7:0]  new_address;
    logic [2:0]  phase;
    logic        protocol_error;

    modport source (
        output valid, tx_action, tx_count, source_select, source_offset, out_deliver,
               out_bytes, address_write, new_address, phase, protocol_error,
        input  ready
    );
    modport sink (
        input  valid, tx_action, tx_count, source_select, source_offset, out_deliver,
               out_bytes, address_write, new_address, phase, protocol_error,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/usb_control_transfer_fsm.sv
// ----------------------------------------------------------------------------
// usb_control_transfer_fsm
// Endpoint-zero control-transfer sequencer with an APB register port.
// ----------------------------------------------------------------------------
// Each SETUP, OUT or IN token event seen on endpoint zero enters as one item
// and produces exactly one result item: the transmit action (stall, a data
// packet with its source and offset, or a zero-length status packet), the
// OUT bytes handed to the vendor handler, a deferred device address write,
// the phase after the event and an error flag. An item is captured in an
// input register; once the result register is empty or being emptied,
// the sequencer state and the result register are updated together from it,
// and the result stays valid until it is taken. One item is taken every
// cycle while the result side keeps up; the rate is set by the single
// state update per cycle. While a finished result waits in the output
// register, the input register takes at most one more item and then holds
// its ready low until the result is taken. The descriptor lengths live in
// five 32-bit registers at byte addresses 0, 4, 8, 12 and 16; they should
// be written only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_control_transfer_fsm #(
    parameter int unsigned PACKET_BYTES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    usbctl_item_if.sink                        i_item,
    usbctl_result_if.source                    o_result,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [usbctl_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [usbctl_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [usbctl_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                               pready
);
    import usbctl_pkg::*;

    // Input register.
    logic    r_in_valid;
    logic    n_in_valid;
    t_item   r_in;

    // Result register.
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;

    // Sequencer state and configuration.
    t_state  r_state;
    t_cfg    r_cfg;

    t_item   in_item;
    t_state  step_state;
    t_result step_result;
    logic    in_take;
    logic    advance;
    logic    cfg_write;

    // The held item moves on whenever the result register is empty or is
    // being emptied this cycle.
    assign advance       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready  = !r_in_valid || advance;
    assign in_take       = i_item.valid && i_item.ready;

    assign n_in_valid  = in_take ? 1'b1 : (advance ? 1'b0 : r_in_valid);
    assign n_out_valid = advance ? 1'b1 : (o_result.ready ? 1'b0 : r_out_valid);

    always_comb begin
        in_item.func             = i_item.func;
        in_item.req_type         = i_item.req_type;
        in_item.req_code         = i_item.req_code;
        in_item.req_value        = i_item.req_value;
        in_item.req_length       = i_item.req_length;
        in_item.rx_count         = i_item.rx_count;
        in_item.vendor_reply_len = i_item.vendor_reply_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= in_item;
        end
        if (advance) begin
            r_out <= step_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, saved_source: SRC_NONE, default: '0};
        end else if (advance) begin
            r_state <= step_state;
        end
    end

    usbctl_step #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_state  (step_state),
        .o_result (step_result)
    );

    assign o_result.valid          = r_out_valid;
    assign o_result.tx_action      = r_out.tx_action;
    assign o_result.tx_count       = r_out.tx_count;
    assign o_result.source_select  = r_out.source_select;
    assign o_result.source_offset  = r_out.source_offset;
    assign o_result.out_deliver    = r_out.out_deliver;
    assign o_result.out_bytes      = r_out.out_bytes;
    assign o_result.address_write  = r_out.address_write;
    assign o_result.new_address    = r_out.new_address;
    assign o_result.phase          = r_out.phase;
    assign o_result.protocol_error = r_out.protocol_error;

    // Configuration registers. Writes complete in the access cycle; only the
    // low bits that a register holds are kept, and unused addresses are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_desc_len <= 8'd18;
            r_cfg.config_desc_len <= 10'd9;
            r_cfg.vendor_str_len  <= 8'd2;
            r_cfg.product_str_len <= 8'd2;
            r_cfg.serial_str_len  <= 8'd2;
        end else if (cfg_write) begin
            case (paddr[4:2])
                REG_DEVICE_DESC: r_cfg.device_desc_len <= pwdata[7:0];
                REG_CONFIG_DESC: r_cfg.config_desc_len <= pwdata[9:0];
                REG_VENDOR_STR:  r_cfg.vendor_str_len  <= pwdata[7:0];
                REG_PRODUCT_STR: r_cfg.product_str_len <= pwdata[7:0];
                REG_SERIAL_STR:  r_cfg.serial_str_len  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_DEVICE_DESC: prdata = {24'd0, r_cfg.device_desc_len};
            REG_CONFIG_DESC: prdata = {22'd0, r_cfg.config_desc_len};
            REG_VENDOR_STR:  prdata = {24'd0, r_cfg.vendor_str_len};
            REG_PRODUCT_STR: prdata = {24'd0, r_cfg.product_str_len};
            REG_SERIAL_STR:  prdata = {24'd0, r_cfg.serial_str_len};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/usbctl_step.sv
// ----------------------------------------------------------------------------
// usbctl_step
// Next-state and result logic for one token event on endpoint zero.
// ----------------------------------------------------------------------------
`default_nettype none

module usbctl_step #(
    parameter int unsigned PACKET_BYTES = 64
) (
    input  usbctl_pkg::t_state  i_state,
    input  usbctl_pkg::t_item   i_item,
    input  usbctl_pkg::t_cfg    i_cfg,
    output usbctl_pkg::t_state  o_state,
    output usbctl_pkg::t_result o_result
);
    import usbctl_pkg::*;

    localparam logic [6:0]  PKT_7  = 7'(PACKET_BYTES);
    localparam logic [15:0] PKT_16 = 16'(PACKET_BYTES);

    logic        set_standard;
    logic        set_to_host;
    logic [4:0]  set_recip;
    logic [3:0]  rep_src;
    logic [15:0] rep_len;
    logic [15:0] cap_src;
    logic [15:0] setup_total;

    logic        is_setup;
    logic [15:0] snd_off;
    logic [15:0] snd_total;
    logic [15:0] snd_len;
    logic [15:0] snd_avail;
    logic [6:0]  snd_n;
    logic [15:0] snd_new_off;
    logic        snd_last;
    logic        do_send;
    logic [15:0] out_off;

    assign set_standard = (i_item.req_type[6:5] == REQ_KIND_STANDARD);
    assign set_to_host  = i_item.req_type[7];
    assign set_recip    = i_item.req_type[4:0];

    // Reply source and length for a standard request carried by a SETUP.
    always_comb begin
        rep_src = SRC_NONE;
        rep_len = '0;
        if (set_recip == RECIP_DEVICE) begin
            case (i_item.req_code)
                REQ_GET_DESCRIPTOR: begin
                    case (i_item.req_value[15:8])
                        DESC_DEVICE: begin
                            rep_src = SRC_DEVICE;
                            rep_len = {8'd0, i_cfg.device_desc_len};
                        end
                        DESC_CONFIG: begin
                            rep_src = SRC_CONFIG;
                            rep_len = {6'd0, i_cfg.config_desc_len};
                        end
                        DESC_STRING: begin
                            if (i_item.req_value[7:2] == 6'd0) begin
                                rep_src = SRC_STRING0 + {2'd0, i_item.req_value[1:0]};
                                case (i_item.req_value[1:0])
                                    2'd0:    rep_len = STRING0_LEN;
                                    2'd1:    rep_len = {8'd0, i_cfg.vendor_str_len};
                                    2'd2:    rep_len = {8'd0, i_cfg.product_str_len};
                                    default: rep_len = {8'd0, i_cfg.serial_str_len};
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
                REQ_GET_CONFIGURATION: begin
                    rep_src = SRC_ZERO;
                    rep_len = ZERO_BYTE_LEN;
                end
                REQ_GET_STATUS: begin
                    rep_src = SRC_STATUS;
                    rep_len = STATUS_BYTES_LEN;
                end
                default: ;
            endcase
        end else if ((set_recip inside {RECIP_INTERFACE, RECIP_ENDPOINT}) &&
                     i_item.req_code == REQ_GET_STATUS) begin
            rep_src = SRC_ZERO;
            rep_len = ZERO_BYTE_LEN;
        end
    end

    // The reply is clipped to what the host asked for.
    assign cap_src     = set_standard ? rep_len : i_item.vendor_reply_len;
    assign setup_total = (cap_src > i_item.req_length) ? i_item.req_length : cap_src;

    // Shared packet builder: a SETUP starts at offset zero, an IN continues.
    assign is_setup    = (i_item.func == FUNC_SETUP);
    assign snd_off     = is_setup ? 16'd0 : i_state.byte_offset;
    assign snd_total   = is_setup ? setup_total : i_state.byte_total;
    assign snd_len     = is_setup ? i_item.req_length : i_state.saved_length;
    assign snd_avail   = (snd_total > snd_off) ? (snd_total - snd_off) : 16'd0;
    assign snd_n       = (snd_avail > PKT_16) ? PKT_7 : snd_avail[6:0];
    assign snd_new_off = snd_off + {9'd0, snd_n};
    assign snd_last    = (snd_new_off == snd_len) || (snd_n < PKT_7);

    assign out_off     = i_state.byte_offset + {9'd0, i_item.rx_count};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        do_send  = 1'b0;
        case (i_item.func)
            FUNC_SETUP: begin
                o_state.saved_type   = i_item.req_type;
                o_state.saved_code   = i_item.req_code;
                o_state.saved_value  = i_item.req_value;
                o_state.saved_length = i_item.req_length;
                o_state.byte_total   = '0;
                o_state.saved_source = SRC_NONE;
                if (set_standard) begin
                    if (set_to_host) begin
                        if (rep_len != 16'd0) begin
                            o_state.saved_source = rep_src;
                            do_send = 1'b1;
                        end else begin
                            o_result.tx_action = TX_STALL;
                            o_state.phase      = PH_IDLE;
                        end
                    end else if (i_item.req_length == 16'd0) begin
                        o_result.tx_action = TX_ZLP;
                        o_state.phase      = PH_STATUS_IN;
                    end else begin
                        o_result.tx_action = TX_STALL;
                        o_state.phase      = PH_IDLE;
                    end
                end else if (set_to_host) begin
                    if (i_item.req_length == 16'd0 || i_item.vendor_reply_len == 16'd0) begin
                        o_result.tx_action = TX_ZLP;
                        o_state.phase      = PH_STATUS_IN;
                    end else if (i_item.vendor_reply_len == VENDOR_ON_THE_FLY) begin
                        o_result.tx_action      = TX_STALL;
                        o_result.protocol_error = 1'b1;
                        o_state.phase           = PH_IDLE;
                    end else begin
                        o_state.saved_source = SRC_USER;
                        do_send = 1'b1;
                    end
                end else if (i_item.req_length == 16'd0) begin
                    o_result.tx_action = TX_ZLP;
                    o_state.phase      = PH_STATUS_IN;
                end else begin
                    o_state.saved_source = SRC_USER;
                    o_state.phase        = PH_OUT_DATA;
                    o_state.byte_offset  = '0;
                    o_state.byte_total   = i_item.req_length;
                end
            end
            FUNC_OUT: begin
                if (i_state.phase == PH_OUT_DATA) begin
                    o_state.byte_offset = out_off;
                    if (i_state.saved_type[6:5] != REQ_KIND_STANDARD) begin
                        o_result.out_deliver = 1'b1;
                        o_result.out_bytes   = i_item.rx_count;
                    end
                    if (out_off == i_state.byte_total) begin
                        o_result.tx_action = TX_ZLP;
                        o_state.phase      = PH_STATUS_IN;
                    end
                end
            end
            FUNC_IN: begin
                case (i_state.phase)
                    PH_STATUS_IN: begin
                        // An address assignment takes effect once its status stage is done.
                        if (i_state.saved_type[6:5] == REQ_KIND_STANDARD &&
                            i_state.saved_type[4:0] == RECIP_DEVICE &&
                            i_state.saved_code == REQ_ASSIGN_ADDRESS) begin
                            o_result.address_write = 1'b1;
                            o_result.new_address   = i_state.saved_value[7:0];
                            o_result.tx_action     = TX_STALL;
                        end
                        o_state.phase = PH_IDLE;
                    end
                    PH_IN_DATA: do_send = 1'b1;
                    PH_LAST_IN: o_state.phase = PH_STATUS_OUT;
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (do_send) begin
            o_result.tx_action      = TX_DATA;
            o_result.tx_count       = snd_n;
            o_result.source_select  = o_state.saved_source;
            o_result.source_offset  = snd_off;
            o_result.protocol_error = (snd_n == 7'd0);
            o_state.byte_offset     = snd_new_off;
            o_state.byte_total      = snd_last ? 16'd0 : snd_total;
            o_state.phase           = snd_last ? PH_LAST_IN : PH_IN_DATA;
        end

        o_result.phase = o_state.phase;
    end

endmodule

`default_nettype wire

FILE: dv/tb_usb_control_transfer_fsm.sv
// ----------------------------------------------------------------------------
// tb_usb_control_transfer_fsm
// Self-checking bench for the endpoint-zero control-transfer sequencer.
// ----------------------------------------------------------------------------
// Token events go in on a valid/ready channel and transmit results come back
// on another. The bench keeps its own model of the sequencer (phase, offsets,
// saved request, descriptor lengths). Every accepted token is run through the
// model and the expected result is queued. Each result the block hands out is
// compared field by field with the oldest queued expectation. Stimulus starts
// with directed standard and vendor transfers, then sweeps the descriptor
// length registers, and finishes with random well-formed transfers mixed with
// stray tokens, random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_usb_control_transfer_fsm;
    import usbctl_pkg::*;

    localparam int unsigned PACKET_BYTES  = 64;
    localparam logic [6:0]  FULL_PACKET   = 7'd64;
    // Token code that the block defines no behavior for.
    localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
    // Length of the long output hold-off, in clock cycles.
    localparam int unsigned HOLD_CYCLES   = 200;
    // Cycles allowed after the last expected result before anything else happens.
    localparam int unsigned SETTLE_CYCLES = 4;
    // Tokens sent after a SETUP before the transfer is given up on.
    localparam int unsigned MAX_STEPS     = 20;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    usbctl_item_if   token_if ();
    usbctl_result_if answer_if ();

    usb_control_transfer_fsm #(
        .PACKET_BYTES (PACKET_BYTES)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (token_if),
        .o_result (answer_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Model state, descriptor lengths and the queue of expected results.
    t_state      ep0;
    t_cfg        desc_lens;
    t_result     pending_responses[$];
    int unsigned mismatch_count = 0;
    int unsigned tokens_sent = 0;

    // Idling controls shared by the test tasks and the result sink.
    bit token_gaps = 1'b0;
    bit answer_stalls = 1'b0;
    bit hold_answers = 1'b0;

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------

    function automatic void reset_model();
        ep0 = '0;
        ep0.phase = PH_IDLE;
        desc_lens.device_desc_len = 8'd18;
        desc_lens.config_desc_len = 10'd9;
        desc_lens.vendor_str_len  = 8'd2;
        desc_lens.product_str_len = 8'd2;
        desc_lens.serial_str_len  = 8'd2;
    endfunction

    // Sends the next IN data packet from the saved source. A short packet, or
    // one that reaches the requested length, closes the data stage.
    function automatic void next_in_packet(inout t_result r);
        logic [15:0] n;
        n = (ep0.byte_total > ep0.byte_offset) ? ep0.byte_total - ep0.byte_offset : 16'd0;
        if (n > PACKET_BYTES) n = 16'(PACKET_BYTES);
        r.tx_action     = TX_DATA;
        r.tx_count      = n[6:0];
        r.source_select = ep0.saved_source;
        r.source_offset = ep0.byte_offset;
        // A packet with nothing in it still goes out, but it is flagged.
        if (n == 16'd0) r.protocol_error = 1'b1;
        ep0.byte_offset = ep0.byte_offset + n;
        if (ep0.byte_offset == ep0.saved_length || n < PACKET_BYTES) begin
            ep0.byte_total = '0;
            ep0.phase = PH_LAST_IN;
        end else begin
            ep0.phase = PH_IN_DATA;
        end
    endfunction

    // Reply source and length of a standard device-to-host request. A zero
    // length means the request is not supported and gets a stall.
    function automatic void standard_source(output logic [3:0] src, output logic [15:0] len);
        logic [7:0] dtype;
        logic [7:0] idx;
        logic [4:0] recip;
        src   = SRC_NONE;
        len   = '0;
        dtype = ep0.saved_value[15:8];
        idx   = ep0.saved_value[7:0];
        recip = ep0.saved_type[4:0];
        if (recip == RECIP_DEVICE) begin
            if (ep0.saved_code == REQ_GET_DESCRIPTOR) begin
                if (dtype == DESC_DEVICE) begin
                    src = SRC_DEVICE;
                    len = {8'd0, desc_lens.device_desc_len};
                end else if (dtype == DESC_CONFIG) begin
                    src = SRC_CONFIG;
                    len = {6'd0, desc_lens.config_desc_len};
                end else if (dtype == DESC_STRING && idx <= 8'd3) begin
                    src = SRC_STRING0 + idx[3:0];
                    case (idx[1:0])
                        2'd0: len = STRING0_LEN;
                        2'd1: len = {8'd0, desc_lens.vendor_str_len};
                        2'd2: len = {8'd0, desc_lens.product_str_len};
                        default: len = {8'd0, desc_lens.serial_str_len};
                    endcase
                end
            end else if (ep0.saved_code == REQ_GET_CONFIGURATION) begin
                src = SRC_ZERO;
                len = ZERO_BYTE_LEN;
            end else if (ep0.saved_code == REQ_GET_STATUS) begin
                src = SRC_STATUS;
                len = STATUS_BYTES_LEN;
            end
        end else if ((recip == RECIP_INTERFACE || recip == RECIP_ENDPOINT) &&
                     ep0.saved_code == REQ_GET_STATUS) begin
            src = SRC_ZERO;
            len = ZERO_BYTE_LEN;
        end
    endfunction

    // Advances the model by one token and returns the result it must cause.
    function automatic t_result predict_response(input t_item it);
        t_result     r;
        logic [3:0]  src;
        logic [15:0] len;
        logic        std_req;
        logic        to_host;
        r = '0;
        case (it.func)
            FUNC_SETUP: begin
                ep0.saved_type   = it.req_type;
                ep0.saved_code   = it.req_code;
                ep0.saved_value  = it.req_value;
                ep0.saved_length = it.req_length;
                ep0.byte_total   = '0;
                ep0.saved_source = SRC_NONE;
                std_req = (it.req_type[6:5] == REQ_KIND_STANDARD);
                to_host = it.req_type[7];
                if (std_req && to_host) begin
                    standard_source(src, len);
                    if (len != 16'd0) begin
                        ep0.saved_source = src;
                        ep0.byte_total = (len > ep0.saved_length) ? ep0.saved_length : len;
                        ep0.byte_offset = '0;
                        next_in_packet(r);
                    end else begin
                        r.tx_action = TX_STALL;
                        ep0.phase = PH_IDLE;
                    end
                end else if (std_req) begin
                    // Standard requests from the host never carry data here.
                    if (ep0.saved_length == 16'd0) begin
                        r.tx_action = TX_ZLP;
                        ep0.phase = PH_STATUS_IN;
                    end else begin
                        r.tx_action = TX_STALL;
                        ep0.phase = PH_IDLE;
                    end
                end else if (to_host) begin
                    if (ep0.saved_length == 16'd0 || it.vendor_reply_len == 16'd0) begin
                        r.tx_action = TX_ZLP;
                        ep0.phase = PH_STATUS_IN;
                    end else if (it.vendor_reply_len == VENDOR_ON_THE_FLY) begin
                        // Data on the fly is not supported: stall and flag it.
                        r.tx_action = TX_STALL;
                        r.protocol_error = 1'b1;
                        ep0.phase = PH_IDLE;
                    end else begin
                        ep0.saved_source = SRC_USER;
                        ep0.byte_total = (it.vendor_reply_len > ep0.saved_length) ?
                                         ep0.saved_length : it.vendor_reply_len;
                        ep0.byte_offset = '0;
                        next_in_packet(r);
                    end
                end else if (ep0.saved_length == 16'd0) begin
                    r.tx_action = TX_ZLP;
                    ep0.phase = PH_STATUS_IN;
                end else begin
                    // Vendor OUT data stage: nothing is sent yet.
                    ep0.saved_source = SRC_USER;
                    ep0.phase = PH_OUT_DATA;
                    ep0.byte_offset = '0;
                    ep0.byte_total = ep0.saved_length;
                end
            end
            FUNC_OUT: begin
                std_req = (ep0.saved_type[6:5] == REQ_KIND_STANDARD);
                if (ep0.phase == PH_OUT_DATA) begin
                    ep0.byte_offset = ep0.byte_offset + {9'd0, it.rx_count};
                    if (!std_req) begin
                        r.out_deliver = 1'b1;
                        r.out_bytes = it.rx_count;
                    end
                    // Only an exact hit ends the stage; an overrun keeps going.
                    if (ep0.byte_offset == ep0.byte_total) begin
                        r.tx_action = TX_ZLP;
                        ep0.phase = PH_STATUS_IN;
                    end
                end
            end
            FUNC_IN: begin
                std_req = (ep0.saved_type[6:5] == REQ_KIND_STANDARD);
                if (ep0.phase == PH_STATUS_IN) begin
                    // The new address only takes effect once its status stage
                    // has been sent.
                    if (std_req && ep0.saved_type[4:0] == RECIP_DEVICE &&
                        ep0.saved_code == REQ_ASSIGN_ADDRESS) begin
                        r.address_write = 1'b1;
                        r.new_address = ep0.saved_value[7:0];
                        r.tx_action = TX_STALL;
                    end
                    ep0.phase = PH_IDLE;
                end else if (ep0.phase == PH_IN_DATA) begin
                    next_in_packet(r);
                end else if (ep0.phase == PH_LAST_IN) begin
                    ep0.phase = PH_STATUS_OUT;
                end
            end
            default: begin
            end
        endcase
        r.phase = ep0.phase;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Every result accepted by the bench is matched against the oldest
    // expectation. Values are read at the edge, before the block updates them.
    always @(posedge i_clk) begin : compare_answers
        t_result want;
        if (i_rst_n && answer_if.valid && answer_if.ready) begin
            if (pending_responses.size() == 0) begin
                $error("result item arrived with no token outstanding");
                mismatch_count++;
            end else begin
                want = pending_responses.pop_front();
                check_field("tx_action", 16'(want.tx_action), 16'(answer_if.tx_action));
                check_field("tx_count", 16'(want.tx_count), 16'(answer_if.tx_count));
                check_field("source_select", 16'(want.source_select),
                            16'(answer_if.source_select));
                check_field("source_offset", want.source_offset, answer_if.source_offset);
                check_field("out_deliver", 16'(want.out_deliver), 16'(answer_if.out_deliver));
                check_field("out_bytes", 16'(want.out_bytes), 16'(answer_if.out_bytes));
                check_field("address_write", 16'(want.address_write),
                            16'(answer_if.address_write));
                check_field("new_address", 16'(want.new_address), 16'(answer_if.new_address));
                check_field("phase", 16'(want.phase), 16'(answer_if.phase));
                check_field("protocol_error", 16'(want.protocol_error),
                            16'(answer_if.protocol_error));
            end
        end
    end

    // Result sink. Normally ready; with stalls enabled it drops ready for
    // random bursts, and on request it holds off for a long counted stretch
    // so that the block backs up and stops taking tokens.
    initial begin : answer_sink
        answer_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_answers) begin
                answer_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_answers = 1'b0;
            end else if (answer_stalls && $urandom_range(0, 7) == 0) begin
                answer_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                answer_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Token and register drivers
    // ------------------------------------------------------------------------

    // Offers one token, waits for the block to take it, then queues the
    // expected result. Valid stays high after acceptance so that back-to-back
    // tokens are offered without a drop in valid.
    task automatic send_token(input t_item it);
        if (token_gaps && $urandom_range(0, 5) == 0) begin
            token_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        token_if.valid            <= 1'b1;
        token_if.func             <= it.func;
        token_if.req_type         <= it.req_type;
        token_if.req_code         <= it.req_code;
        token_if.req_value        <= it.req_value;
        token_if.req_length       <= it.req_length;
        token_if.rx_count         <= it.rx_count;
        token_if.vendor_reply_len <= it.vendor_reply_len;
        @(posedge i_clk);
        while (!token_if.ready) @(posedge i_clk);
        pending_responses.push_back(predict_response(it));
        tokens_sent++;
    endtask

    // Stops offering tokens and waits until every expected result is in and
    // the pipeline has had time to empty.
    task automatic settle();
        token_if.valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: a setup phase, then an access phase until pready.
    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        // Only the low bits of each register are kept.
        case (index)
            REG_DEVICE_DESC:  desc_lens.device_desc_len = value[7:0];
            REG_CONFIG_DESC:  desc_lens.config_desc_len = value[9:0];
            REG_VENDOR_STR:   desc_lens.vendor_str_len  = value[7:0];
            REG_PRODUCT_STR:  desc_lens.product_str_len = value[7:0];
            REG_SERIAL_STR:   desc_lens.serial_str_len  = value[7:0];
            default: begin
            end
        endcase
    endtask

    task automatic program_lengths(input logic [31:0] device_len, input logic [31:0] config_len,
                                   input logic [31:0] vendor_len, input logic [31:0] product_len,
                                   input logic [31:0] serial_len);
        write_register(REG_DEVICE_DESC, device_len);
        write_register(REG_CONFIG_DESC, config_len);
        write_register(REG_VENDOR_STR, vendor_len);
        write_register(REG_PRODUCT_STR, product_len);
        write_register(REG_SERIAL_STR, serial_len);
    endtask

    // ------------------------------------------------------------------------
    // Token generators
    // ------------------------------------------------------------------------

    function automatic t_item random_token();
        t_item it;
        it.func             = 2'($urandom);
        it.req_type         = 8'($urandom);
        it.req_code         = 8'($urandom);
        it.req_value        = 16'($urandom);
        it.req_length       = 16'($urandom);
        it.rx_count         = 7'($urandom);
        it.vendor_reply_len = 16'($urandom);
        return it;
    endfunction

    // Fields that the token type does not use are left random.
    function automatic t_item make_token(input logic [1:0] func, input logic [6:0] rx);
        t_item it;
        it = random_token();
        it.func = func;
        it.rx_count = rx;
        return it;
    endfunction

    function automatic t_item make_setup(input logic [7:0] req_type, input logic [7:0] req_code,
                                         input logic [15:0] req_value,
                                         input logic [15:0] req_length,
                                         input logic [15:0] reply_len);
        t_item it;
        it = make_token(FUNC_SETUP, 7'd0);
        it.req_type         = req_type;
        it.req_code         = req_code;
        it.req_value        = req_value;
        it.req_length       = req_length;
        it.vendor_reply_len = reply_len;
        return it;
    endfunction

    // Host lengths are mostly small so that transfers stay short; some hit the
    // all-ones and fully random corners.
    function automatic logic [15:0] request_length();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 3));
            2: return 16'hFFFF;
            default: return 16'($urandom_range(0, 200));
        endcase
    endfunction

    // A SETUP drawn from the request classes the sequencer tells apart.
    function automatic t_item random_setup();
        t_item      it;
        logic [4:0] recip;
        logic [1:0] kind;
        it = make_token(FUNC_SETUP, 7'($urandom));
        it.req_length = request_length();
        kind = 2'($urandom_range(1, 3));
        case ($urandom_range(0, 9))
            0: recip = 5'($urandom);
            1: recip = 5'($urandom_range(1, 2));
            default: recip = RECIP_DEVICE;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                it.req_type = {1'b1, REQ_KIND_STANDARD, recip};
                it.req_code = REQ_GET_DESCRIPTOR;
                it.req_value[15:8] = ($urandom_range(0, 5) == 0) ? 8'($urandom) :
                                     8'($urandom_range(1, 3));
                it.req_value[7:0]  = ($urandom_range(0, 5) == 0) ? 8'($urandom) :
                                     8'($urandom_range(0, 4));
            end
            4: begin
                it.req_type = {1'b1, REQ_KIND_STANDARD, recip};
                it.req_code = ($urandom_range(0, 1) == 0) ? REQ_GET_STATUS : REQ_GET_CONFIGURATION;
                if ($urandom_range(0, 3) == 0) it.req_type[4:0] = 5'($urandom_range(1, 2));
            end
            5: begin
                it.req_type = {1'b0, REQ_KIND_STANDARD, recip};
                it.req_code = ($urandom_range(0, 1) == 0) ? REQ_ASSIGN_ADDRESS : 8'($urandom);
                if ($urandom_range(0, 3) != 0) it.req_length = '0;
            end
            6, 7: begin
                it.req_type = {1'b1, kind, recip};
                case ($urandom_range(0, 7))
                    0: it.vendor_reply_len = '0;
                    1: it.vendor_reply_len = VENDOR_ON_THE_FLY;
                    2: it.vendor_reply_len = 16'($urandom);
                    default: it.vendor_reply_len = 16'($urandom_range(1, 200));
                endcase
            end
            8: begin
                it.req_type = {1'b0, kind, recip};
            end
            default: begin
                // Leave the request fully random.
            end
        endcase
        return it;
    endfunction

    // OUT payload size: normally what is still owed, up to one packet.
    function automatic logic [6:0] out_chunk();
        logic [15:0] owed;
        owed = ep0.byte_total - ep0.byte_offset;
        if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
        return (owed > PACKET_BYTES) ? FULL_PACKET : owed[6:0];
    endfunction

    // One control transfer as a host would run it: SETUP, then the tokens
    // that the current phase calls for, with an occasional stray token. A
    // transfer that runs too long is abandoned by the next SETUP.
    task automatic run_one_transfer();
        int unsigned steps;
        send_token(random_setup());
        steps = 0;
        while (ep0.phase != PH_IDLE && steps < MAX_STEPS) begin
            steps++;
            if ($urandom_range(0, 11) == 0) begin
                send_token(random_token());
            end else if (ep0.phase == PH_STATUS_OUT) begin
                // Zero-length status OUT; the bench then stops driving this transfer.
                send_token(make_token(FUNC_OUT, 7'd0));
                steps = MAX_STEPS;
            end else if (ep0.phase == PH_OUT_DATA) begin
                send_token(make_token(FUNC_OUT, out_chunk()));
            end else begin
                send_token(make_token(FUNC_IN, 7'($urandom)));
            end
        end
    endtask

    task automatic run_transfers(input int unsigned count);
        int unsigned goal;
        goal = tokens_sent + count;
        while (tokens_sent < goal) run_one_transfer();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Standard requests with the reset descriptor lengths, plus tokens that
    // arrive when the sequencer has no use for them.
    task automatic test_standard_requests();
        t_item it;
        // The unused token code with every other field at its maximum does
        // nothing.
        it = '1;
        it.func = FUNC_UNUSED;
        send_token(it);
        // IN and OUT while idle are ignored.
        send_token(make_token(FUNC_IN, 7'd0));
        send_token(make_token(FUNC_OUT, 7'h7F));
        // An all-zero SETUP is a host-to-device standard request without data.
        it = '0;
        send_token(it);
        send_token(make_token(FUNC_IN, 7'd0));
        // Device descriptor, shorter than the host asks: one short packet,
        // then the status OUT. An OUT in status-out leaves the phase alone.
        send_token(make_setup(8'h80, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'hFFFF, 16'd0));
        send_token(make_token(FUNC_IN, 7'd0));
        send_token(make_token(FUNC_OUT, 7'd0));
        // Configuration descriptor cut to the host length.
        send_token(make_setup(8'h80, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'd4, 16'd0));
        // A string index above three has no data and stalls.
        send_token(make_setup(8'h80, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h04}, 16'd255, 16'd0));
        send_token(make_setup(8'h80, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h00}, 16'd255, 16'd0));
        send_token(make_setup(8'h80, REQ_GET_CONFIGURATION, 16'd0, 16'd1, 16'd0));
        send_token(make_setup({1'b1, REQ_KIND_STANDARD, RECIP_ENDPOINT}, REQ_GET_STATUS,
                              16'd0, 16'd2, 16'd0));
        // Unknown standard request to the host: nothing to answer.
        send_token(make_setup(8'h80, 8'hFF, 16'd0, 16'd8, 16'd0));
        // Host-to-device standard request that claims a data stage.
        send_token(make_setup(8'h00, 8'd9, 16'd1, 16'd1, 16'd0));
        // An address assignment writes the address only when its status IN
        // completes.
        send_token(make_setup(8'h00, REQ_ASSIGN_ADDRESS, 16'h00FF, 16'd0, 16'd0));
        send_token(make_token(FUNC_IN, 7'd0));
        settle();
    endtask

    // Vendor requests in both directions, including the empty IN packet and
    // the unsupported on-the-fly reply.
    task automatic test_vendor_requests();
        send_token(make_setup(8'hC0, 8'h55, 16'h1234, 16'd10, VENDOR_ON_THE_FLY));
        send_token(make_setup(8'hC0, 8'h55, 16'h1234, 16'd10, 16'd0));
        // A full first packet that does not reach the host length leaves one
        // more IN, which then finds nothing left and goes out empty.
        send_token(make_setup(8'hC0, 8'hAA, 16'h0000, 16'd200, 16'd64));
        send_token(make_token(FUNC_IN, 7'd0));
        send_token(make_token(FUNC_IN, 7'd0));
        // Vendor OUT data stage of 100 bytes in two packets.
        send_token(make_setup(8'h40, 8'h01, 16'hFFFF, 16'd100, 16'hFFFF));
        send_token(make_token(FUNC_OUT, 7'd64));
        send_token(make_token(FUNC_OUT, 7'd36));
        send_token(make_token(FUNC_IN, 7'd0));
        settle();
    endtask

    // Several descriptor length settings, extremes first. Each phase starts
    // from an idle block and runs random transfers against the new lengths.
    task automatic test_register_settings();
        token_gaps = 1'b1;
        answer_stalls = 1'b1;
        // All zero: every descriptor request but string zero stalls.
        program_lengths(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        run_transfers(50);
        settle();
        // All ones: only the low bits survive, giving the largest lengths.
        program_lengths('1, '1, '1, '1, '1);
        run_transfers(50);
        settle();
        // Lengths on and around packet boundaries.
        program_lengths(32'd64, 32'd128, 32'd63, 32'd65, 32'd1);
        run_transfers(50);
        settle();
        repeat (2) begin
            program_lengths($urandom, $urandom, $urandom, $urandom, $urandom);
            run_transfers(50);
            settle();
        end
    endtask

    // Random transfers under every mix of input gaps and output stalls.
    task automatic test_random_traffic();
        for (int seg = 0; seg < 4; seg++) begin
            token_gaps = seg[0];
            answer_stalls = seg[1];
            run_transfers(120);
        end
        settle();
    endtask

    // The sink holds off for a long stretch while tokens keep coming, so the
    // block fills up and must stall its input.
    task automatic test_output_backpressure();
        token_gaps = 1'b0;
        answer_stalls = 1'b0;
        hold_answers = 1'b1;
        run_transfers(150);
        wait (hold_answers == 1'b0);
        settle();
    endtask

    // Closing stretch at full rate with no idling on either side.
    task automatic test_steady_stream();
        token_gaps = 1'b0;
        answer_stalls = 1'b0;
        run_transfers(150);
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n                   <= 1'b0;
        token_if.valid            <= 1'b0;
        token_if.func             <= FUNC_SETUP;
        token_if.req_type         <= '0;
        token_if.req_code         <= '0;
        token_if.req_value        <= '0;
        token_if.req_length       <= '0;
        token_if.rx_count         <= '0;
        token_if.vendor_reply_len <= '0;
        psel                      <= 1'b0;
        penable                   <= 1'b0;
        pwrite                    <= 1'b0;
        paddr                     <= '0;
        pwdata                    <= '0;
        reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_standard_requests();
        test_vendor_requests();
        test_register_settings();
        test_random_traffic();
        test_output_backpressure();
        test_steady_stream();

        if (mismatch_count == 0) begin
            $display("usb_control_transfer_fsm: match");
        end else begin
            $display("usb_control_transfer_fsm: mismatch");
        end
        $finish;
    end

    // A hung handshake ends the run here, far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("usb_control_transfer_fsm: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/usbctl_pkg.sv
hw/rtl/usbctl_if.sv
hw/rtl/usbctl_step.sv
hw/rtl/usb_control_transfer_fsm.sv
dv/tb_usb_control_transfer_fsm.sv
